### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, muted while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed while out of reset");

// Concurrent assertion that also runs during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### rtl/gcd_pkg.sv
`default_nettype none

package gcd_pkg;

  localparam int WIDTH  = 32;
  localparam int TWOS_W = $clog2(WIDTH);
  localparam int IN_W   = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_W  = ((WIDTH + 7) / 8) * 8;

  // Command broadcast to every bit cell.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHR_BOTH,
    OP_SHR_X,
    OP_SHR_Y,
    OP_SUB,
    OP_SHL_X
  } cell_op_t;

  typedef struct packed {
    logic x_lsb;
    logic y_lsb;
    logic y_zero;
  } arr_status_t;

endpackage

`default_nettype wire

### rtl/binary_gcd_unit.sv
// Flow: a request is loaded, shared factors of two are stripped and counted (t), x is made odd,
// then the bit-cell row shifts y odd and subtracts until y is zero, and x is shifted back by t;
// when either operand is zero the stripping and odd-making steps are skipped.
// A new request is taken only once the result sits in the output register, but then even
// while that result waits for m_tready.
// Reset: rst is synchronous, active high; it returns to idle and drops m_tvalid.
`default_nettype none

module binary_gcd_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // s_tdata from bit 0: operand_a, operand_b
  input  logic [gcd_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // m_tdata from bit 0: divisor
  output logic [gcd_pkg::OUT_W-1:0] m_tdata
);
  import gcd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TWOS,
    S_ODDX,
    S_LOOP,
    S_FIX,
    S_OUT
  } state_t;

  state_t              state;
  logic [TWOS_W-1:0]   twos;
  cell_op_t            op;
  arr_status_t         status;
  logic [WIDTH-1:0]    x_vec;
  logic [WIDTH-1:0]    opa;
  logic [WIDTH-1:0]    opb;
  logic                any_zero;
  logic [WIDTH-1:0]    load_a;
  logic [WIDTH-1:0]    load_b;

  assign opa      = s_tdata[WIDTH-1:0];
  assign opb      = s_tdata[2*WIDTH-1:WIDTH];
  assign any_zero = (opa == '0) || (opb == '0);
  // with one operand zero the other is the answer: park it in x, y = 0
  assign load_a   = any_zero ? (opa | opb) : opa;
  assign load_b   = any_zero ? '0 : opb;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    op = OP_HOLD;
    case (state)
      S_IDLE: if (s_tvalid) op = OP_LOAD;
      S_TWOS: if (!status.x_lsb && !status.y_lsb) op = OP_SHR_BOTH;
      S_ODDX: if (!status.x_lsb) op = OP_SHR_X;
      S_LOOP: begin
        if (status.y_zero) op = OP_HOLD;
        else if (!status.y_lsb) op = OP_SHR_Y;
        else op = OP_SUB;
      end
      S_FIX:  if (twos != '0) op = OP_SHL_X;
      default: op = OP_HOLD;
    endcase
  end

  gcd_array u_array (
    .clk    (clk),
    .op     (op),
    .load_a (load_a),
    .load_b (load_b),
    .x_vec  (x_vec),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      twos     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop a taken result unless a new one is loaded in this cycle
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            twos  <= '0;
            state <= any_zero ? S_LOOP : S_TWOS;
          end
        end
        S_TWOS: begin
          if (!status.x_lsb && !status.y_lsb) twos <= twos + 1'b1;
          else state <= S_ODDX;
        end
        S_ODDX: if (status.x_lsb) state <= S_LOOP;
        S_LOOP: if (status.y_zero) state <= S_FIX;
        S_FIX: begin
          if (twos == '0) state <= S_OUT;
          else twos <= twos - 1'b1;
        end
        S_OUT: begin
          // wait for the output register to free up
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'(x_vec);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/gcd_cell.sv
`default_nettype none

// One bit slice of the operand pair.
module gcd_cell (
  input  logic              clk,
  input  gcd_pkg::cell_op_t op,
  input  logic              swap,
  input  logic              a_bit,
  input  logic              b_bit,
  input  logic              x_hi,
  input  logic              y_hi,
  input  logic              x_lo,
  input  logic              b1_in,
  input  logic              b2_in,
  output logic              x,
  output logic              y,
  output logic              b1_out,
  output logic              b2_out
);
  import gcd_pkg::*;

  logic d1;
  logic d2;

  // y - x and x - y, one borrow chain each
  assign d1     = y ^ x ^ b1_in;
  assign b1_out = (~y & x) | (~(y ^ x) & b1_in);
  assign d2     = x ^ y ^ b2_in;
  assign b2_out = (~x & y) | (~(x ^ y) & b2_in);

  always_ff @(posedge clk) begin
    case (op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        x <= a_bit;
        y <= b_bit;
      end
      OP_SHR_BOTH: begin
        x <= x_hi;
        y <= y_hi;
      end
      OP_SHR_X: x <= x_hi;
      OP_SHR_Y: y <= y_hi;
      OP_SUB: begin
        if (swap) begin
          x <= y;
          y <= d2;
        end else begin
          y <= d1;
        end
      end
      OP_SHL_X: x <= x_lo;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/gcd_array.sv
`default_nettype none

// Row of bit cells, LSB in cell 0, shifts pass between neighbors.
module gcd_array (
  input  logic                       clk,
  input  gcd_pkg::cell_op_t          op,
  input  logic [gcd_pkg::WIDTH-1:0]  load_a,
  input  logic [gcd_pkg::WIDTH-1:0]  load_b,
  output logic [gcd_pkg::WIDTH-1:0]  x_vec,
  output gcd_pkg::arr_status_t       status
);
  import gcd_pkg::*;

  logic [WIDTH-1:0] y_vec;
  logic [WIDTH-1:0] x_up;
  logic [WIDTH-1:0] y_up;
  logic [WIDTH-1:0] x_dn;
  logic [WIDTH:0]   b1c;
  logic [WIDTH:0]   b2c;
  logic             swap;

  assign x_up   = {1'b0, x_vec[WIDTH-1:1]};
  assign y_up   = {1'b0, y_vec[WIDTH-1:1]};
  assign x_dn   = {x_vec[WIDTH-2:0], 1'b0};
  assign b1c[0] = 1'b0;
  assign b2c[0] = 1'b0;

  // borrow out of y - x: x is the larger, so swap the pair
  assign swap = b1c[WIDTH] & ~b2c[WIDTH];

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    gcd_cell u_cell (
      .clk    (clk),
      .op     (op),
      .swap   (swap),
      .a_bit  (load_a[i]),
      .b_bit  (load_b[i]),
      .x_hi   (x_up[i]),
      .y_hi   (y_up[i]),
      .x_lo   (x_dn[i]),
      .b1_in  (b1c[i]),
      .b2_in  (b2c[i]),
      .x      (x_vec[i]),
      .y      (y_vec[i]),
      .b1_out (b1c[i+1]),
      .b2_out (b2c[i+1])
    );
  end

  assign status.x_lsb  = x_vec[0];
  assign status.y_lsb  = y_vec[0];
  assign status.y_zero = ~|y_vec;

endmodule

`default_nettype wire

### rtl/gcd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module gcd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [gcd_pkg::OUT_W-1:0] m_tdata
);
  import gcd_pkg::*;

  `ASSERT_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `ASSERT_RST(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata))
  `ASSERT_RST(a_busy_after_req, clk, rst, s_tvalid && s_tready |=> !s_tready)
  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !m_tvalid && s_tready)

endmodule

bind binary_gcd_unit gcd_checker u_gcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
